// ===== sv/fourier_phase_ramp_shift_defines.svh =====
// Assertion macros used by the checker file.
`ifndef FOURIER_PHASE_RAMP_SHIFT_DEFINES_SVH
`define FOURIER_PHASE_RAMP_SHIFT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define FPR_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fpr: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define FPR_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fpr: next-cycle check failed");

`endif

// ===== sv/fpr_pkg.sv =====
package fpr_pkg;

  localparam int PHASE_W      = 24;  // phase accumulators, turn / 2^24
  localparam int DIM_W        = 13;  // width / height registers
  localparam int FRAC_BITS    = 30;  // Q.30 table values
  localparam int SINE_W       = 31;  // table entry, 0 .. 2^30
  localparam int COEF_W       = 32;  // signed cos / sin operand
  localparam int TAYLOR_TERMS = 10;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 4;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam longint      ONE_Q30     = 64'sd1073741824;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_COL_STEP     = 2'd2,
    REG_ROW_STEP     = 2'd3
  } reg_e;

  typedef struct packed {
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [PHASE_W-1:0] column_phase_step;
    logic [PHASE_W-1:0] row_phase_step;
  } cfg_t;

  // Unsigned 64-bit quotient by shift and subtract; only used to build constants.
  function automatic logic [63:0] udiv64(input logic [63:0] num,
                                         input logic [63:0] dvs);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int bit_pos = 63; bit_pos >= 0; bit_pos--) begin
      rem = {rem[63:0], num[bit_pos]};
      if (rem >= {1'b0, dvs}) begin
        rem          = rem - {1'b0, dvs};
        quo[bit_pos] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine entry i of a 2^tbits table, integer Taylor series.
  // Only evaluated at elaboration to build the ROM contents.
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i,
                                                   input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] den;
    longint      sum;
    x    = (HALF_PI_Q30 * 64'(i)) >> tbits;
    x2   = (x * x) >> FRAC_BITS;
    term = x;
    sum  = longint'(x);
    for (int unsigned k = 1; k <= TAYLOR_TERMS; k++) begin
      den  = 64'((2 * k) * (2 * k + 1));
      term = udiv64((term * x2) >> FRAC_BITS, den);
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    return SINE_W'(sum);
  endfunction

endpackage

// ===== sv/fpr_in_if.sv =====
interface fpr_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_real;
  logic signed [SAMPLE_BITS-1:0] sample_imag;

  modport source (output valid, output sample_real, output sample_imag, input ready);
  modport sink (input valid, input sample_real, input sample_imag, output ready);
endinterface

// ===== sv/fpr_out_if.sv =====
interface fpr_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] shifted_real;
  logic signed [SAMPLE_BITS-1:0] shifted_imag;
  logic                          frame_end;

  modport source (output valid, output shifted_real, output shifted_imag,
                  output frame_end, input ready);
  modport sink (input valid, input shifted_real, input shifted_imag,
                input frame_end, output ready);
endinterface

// ===== sv/fpr_cfg_regs.sv =====
module fpr_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fpr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [fpr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [fpr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output fpr_pkg::cfg_t                    cfg_o
);

  fpr_pkg::cfg_t cfg_q;
  fpr_pkg::reg_e sel;
  logic          wr_en;

  assign sel    = fpr_pkg::reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width       <= fpr_pkg::DIM_W'(1);
      cfg_q.image_height      <= fpr_pkg::DIM_W'(1);
      cfg_q.column_phase_step <= '0;
      cfg_q.row_phase_step    <= '0;
    end else if (wr_en) begin
      unique case (sel)
        fpr_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width <= pwdata[fpr_pkg::DIM_W-1:0];
        fpr_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[fpr_pkg::DIM_W-1:0];
        fpr_pkg::REG_COL_STEP:     cfg_q.column_phase_step <= pwdata[fpr_pkg::PHASE_W-1:0];
        fpr_pkg::REG_ROW_STEP:     cfg_q.row_phase_step <= pwdata[fpr_pkg::PHASE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      fpr_pkg::REG_IMAGE_WIDTH:  prdata = fpr_pkg::APB_DATA_W'(cfg_q.image_width);
      fpr_pkg::REG_IMAGE_HEIGHT: prdata = fpr_pkg::APB_DATA_W'(cfg_q.image_height);
      fpr_pkg::REG_COL_STEP:     prdata = fpr_pkg::APB_DATA_W'(cfg_q.column_phase_step);
      fpr_pkg::REG_ROW_STEP:     prdata = fpr_pkg::APB_DATA_W'(cfg_q.row_phase_step);
    endcase
  end

endmodule

// ===== sv/fpr_scan_ctrl.sv =====
module fpr_scan_ctrl #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fpr_pkg::cfg_t                 cfg_i,
  input  logic                          step_i,
  output logic [fpr_pkg::PHASE_W-1:0]   phase_o,
  output logic                          frame_end_o
);

  localparam int IDX_W = $clog2(MAX_DIMENSION);
  localparam int CMP_W = (IDX_W + 1 > fpr_pkg::DIM_W) ? IDX_W + 1 : fpr_pkg::DIM_W;
  localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(MAX_DIMENSION);

  logic [IDX_W-1:0]            col_idx_q, col_idx_d;
  logic [IDX_W-1:0]            row_idx_q, row_idx_d;
  logic [fpr_pkg::PHASE_W-1:0] col_phase_q, col_phase_d;
  logic [fpr_pkg::PHASE_W-1:0] row_phase_q, row_phase_d;
  logic [CMP_W-1:0]            width_eff, height_eff;
  logic                        last_col, last_row;

  // Zero acts as one, oversize acts as the maximum.
  function automatic logic [CMP_W-1:0] clamp_dim(input logic [fpr_pkg::DIM_W-1:0] d);
    logic [CMP_W-1:0] w;
    w = CMP_W'(d);
    if (d == '0) begin
      return CMP_W'(1);
    end else if (w > DIM_MAX) begin
      return DIM_MAX;
    end
    return w;
  endfunction

  assign width_eff  = clamp_dim(cfg_i.image_width);
  assign height_eff = clamp_dim(cfg_i.image_height);

  // ">=" so that an index left past a shrunk size still closes its row / frame.
  assign last_col    = (CMP_W'(col_idx_q) + CMP_W'(1)) >= width_eff;
  assign last_row    = (CMP_W'(row_idx_q) + CMP_W'(1)) >= height_eff;
  assign frame_end_o = last_col && last_row;
  assign phase_o     = col_phase_q + row_phase_q;

  always_comb begin
    col_idx_d   = col_idx_q;
    row_idx_d   = row_idx_q;
    col_phase_d = col_phase_q;
    row_phase_d = row_phase_q;
    if (last_col) begin
      col_idx_d   = '0;
      col_phase_d = '0;
      if (last_row) begin
        row_idx_d   = '0;
        row_phase_d = '0;
      end else begin
        row_idx_d   = row_idx_q + IDX_W'(1);
        row_phase_d = row_phase_q + cfg_i.row_phase_step;
      end
    end else begin
      col_idx_d   = col_idx_q + IDX_W'(1);
      col_phase_d = col_phase_q + cfg_i.column_phase_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_idx_q   <= '0;
      row_idx_q   <= '0;
      col_phase_q <= '0;
      row_phase_q <= '0;
    end else if (step_i) begin
      col_idx_q   <= col_idx_d;
      row_idx_q   <= row_idx_d;
      col_phase_q <= col_phase_d;
      row_phase_q <= row_phase_d;
    end
  end

endmodule

// ===== sv/fpr_sine_rom.sv =====
module fpr_sine_rom #(
  parameter int TABLE_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [TABLE_BITS:0]          addr_a_i,
  input  logic [TABLE_BITS:0]          addr_b_i,
  output logic [fpr_pkg::SINE_W-1:0]   data_a_o,
  output logic [fpr_pkg::SINE_W-1:0]   data_b_o
);

  localparam int DEPTH = (1 << TABLE_BITS) + 1;

  logic [fpr_pkg::SINE_W-1:0] rom [DEPTH];

  // Each entry is a constant fixed at elaboration.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_rom
    localparam logic [fpr_pkg::SINE_W-1:0] ENTRY =
      fpr_pkg::sine_entry(unsigned'(gi), unsigned'(TABLE_BITS));
    assign rom[gi] = ENTRY;
  end

  logic [fpr_pkg::SINE_W-1:0] data_a_q, data_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_q <= rom[addr_a_i];
      data_b_q <= rom[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

// ===== sv/fpr_rotator.sv =====
module fpr_rotator #(
  parameter int SAMPLE_BITS     = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          in_valid_i,
  input  logic signed [SAMPLE_BITS-1:0] real_i,
  input  logic signed [SAMPLE_BITS-1:0] imag_i,
  input  logic [fpr_pkg::PHASE_W-1:0]   phase_i,
  input  logic                          frame_end_i,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] real_o,
  output logic signed [SAMPLE_BITS-1:0] imag_o,
  output logic                          frame_end_o
);

  localparam int TBL_N  = 1 << SINE_TABLE_BITS;
  localparam int AW     = SINE_TABLE_BITS + 1;
  localparam int CW     = fpr_pkg::COEF_W;
  localparam int PROD_W = SAMPLE_BITS + CW;
  localparam int SUM_W  = PROD_W + 1;
  localparam int R_W    = SUM_W - fpr_pkg::FRAC_BITS;

  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (fpr_pkg::FRAC_BITS - 1);
  localparam logic signed [R_W-1:0] R_MAX =
    {{(R_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [R_W-1:0] R_MIN =
    {{(R_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  // stage 1: table read
  logic                          v1_q, fe1_q;
  logic signed [SAMPLE_BITS-1:0] a1_q, b1_q;
  quad_e                         quad1_q;
  logic [AW-1:0]                 addr_a, addr_b;
  logic [fpr_pkg::SINE_W-1:0]    tbl_a, tbl_b;
  // stage 2: signed cos / sin
  logic                          v2_q, fe2_q;
  logic signed [SAMPLE_BITS-1:0] a2_q, b2_q;
  logic signed [CW-1:0]          c2_q, s2_q, c2_d, s2_d;
  logic signed [CW-1:0]          pos_a, pos_b;
  // stage 3: products
  logic                          v3_q, fe3_q;
  logic signed [PROD_W-1:0]      p_ac_q, p_bs_q, p_as_q, p_bc_q;
  // stage 4: output register
  logic                          out_valid_q, fe4_q;
  logic signed [SAMPLE_BITS-1:0] re4_q, im4_q, re4_d, im4_d;
  logic signed [SUM_W-1:0]       re_sum, im_sum;

  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
      input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] y;
    logic signed [R_W-1:0]   r;
    y = (x + RND) >>> fpr_pkg::FRAC_BITS;
    r = R_W'(y);
    if (r > R_MAX) begin
      return SAMPLE_BITS'(R_MAX);
    end else if (r < R_MIN) begin
      return SAMPLE_BITS'(R_MIN);
    end
    return SAMPLE_BITS'(r);
  endfunction

  // Read the table at idx and at its complement in the same cycle.
  assign addr_a = {1'b0, phase_i[fpr_pkg::PHASE_W-3 -: SINE_TABLE_BITS]};
  assign addr_b = AW'(TBL_N) - addr_a;

  fpr_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine_rom (
    .clk_i    (clk_i),
    .en_i     (adv_i),
    .addr_a_i (addr_a),
    .addr_b_i (addr_b),
    .data_a_o (tbl_a),
    .data_b_o (tbl_b)
  );

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a1_q    <= real_i;
      b1_q    <= imag_i;
      fe1_q   <= frame_end_i;
      quad1_q <= quad_e'(phase_i[fpr_pkg::PHASE_W-1 -: 2]);
    end
  end

  // Fold the quadrant into sign and table swap.
  assign pos_a = CW'(tbl_a);
  assign pos_b = CW'(tbl_b);

  always_comb begin
    unique case (quad1_q)
      QUAD_0: begin s2_d = pos_a;  c2_d = pos_b;  end
      QUAD_1: begin s2_d = pos_b;  c2_d = -pos_a; end
      QUAD_2: begin s2_d = -pos_a; c2_d = -pos_b; end
      QUAD_3: begin s2_d = -pos_b; c2_d = pos_a;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a2_q  <= a1_q;
      b2_q  <= b1_q;
      c2_q  <= c2_d;
      s2_q  <= s2_d;
      fe2_q <= fe1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_ac_q <= a2_q * c2_q;
      p_bs_q <= b2_q * s2_q;
      p_as_q <= a2_q * s2_q;
      p_bc_q <= b2_q * c2_q;
      fe3_q  <= fe2_q;
    end
  end

  assign re_sum = SUM_W'(p_ac_q) - SUM_W'(p_bs_q);
  assign im_sum = SUM_W'(p_as_q) + SUM_W'(p_bc_q);
  assign re4_d  = round_sat(re_sum);
  assign im4_d  = round_sat(im_sum);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      re4_q <= re4_d;
      im4_q <= im4_d;
      fe4_q <= fe3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign real_o      = re4_q;
  assign imag_o      = im4_q;
  assign frame_end_o = fe4_q;

endmodule

// ===== sv/fourier_phase_ramp_shift.sv =====
// Fourier phase-ramp shift. Streams an image spectrum in row-major order, one
// complex coefficient per item, and rotates each by exp(i*t) where
// t = column*column_phase_step + row*row_phase_step in 24-bit fractions of a
// turn, which translates the image by a sub-pixel amount. Cos and sin come
// from a quarter-wave ROM of 2^SINE_TABLE_BITS+1 Q1.30 entries read at two
// addresses per cycle; the complex product is rounded half up and saturated
// to SAMPLE_BITS. frame_end marks the last coefficient of a frame.
// Throughput is one item per clock unless the output stalls. Stages from input
// accept to output valid: table read, cos/sin select, four multipliers, round
// and saturate. The whole pipeline advances together and holds only while the
// output register is full and not taken, so in_i.ready is low exactly then.
// Registers (APB, byte address 4*i): 0 image_width, 1 image_height (13 bit,
// 0 acts as 1, above MAX_DIMENSION acts as MAX_DIMENSION), 2 column_phase_step,
// 3 row_phase_step (24 bit). Write them only while the block is idle; new
// sizes apply at once.
module fourier_phase_ramp_shift #(
  parameter int MAX_DIMENSION   = 4096,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fpr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [fpr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [fpr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  fpr_in_if.sink                           in_i,
  fpr_out_if.source                        out_o
);

  fpr_pkg::cfg_t               cfg;
  logic                        adv;
  logic                        in_accept;
  logic [fpr_pkg::PHASE_W-1:0] phase;
  logic                        frame_end;
  logic                        out_valid;

  // Advance every stage unless a finished item waits at the output and is not taken.
  assign adv        = !out_valid || out_o.ready;
  assign in_i.ready = adv;
  assign in_accept  = in_i.valid && adv;

  fpr_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Scan position and phase of the item at the input; step on accept.
  fpr_scan_ctrl #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_scan_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (in_accept),
    .phase_o     (phase),
    .frame_end_o (frame_end)
  );

  fpr_rotator #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_rotator (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (in_i.valid),
    .real_i      (in_i.sample_real),
    .imag_i      (in_i.sample_imag),
    .phase_i     (phase),
    .frame_end_i (frame_end),
    .out_valid_o (out_valid),
    .real_o      (out_o.shifted_real),
    .imag_o      (out_o.shifted_imag),
    .frame_end_o (out_o.frame_end)
  );

  assign out_o.valid = out_valid;

endmodule

// ===== sv/fpr_checker.sv =====
`include "fourier_phase_ramp_shift_defines.svh"

module fpr_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             psel_i,
  input logic                             penable_i,
  input logic                             pwrite_i,
  input logic [fpr_pkg::APB_ADDR_W-1:0]   paddr_i,
  input logic [fpr_pkg::APB_DATA_W-1:0]   pwdata_i,
  input logic [fpr_pkg::APB_DATA_W-1:0]   prdata_i,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [SAMPLE_BITS-1:0]    out_real_i,
  input logic signed [SAMPLE_BITS-1:0]    out_imag_i,
  input logic                             out_frame_end_i
);

  logic col_step_wr;
  logic stalled;

  assign col_step_wr = psel_i && penable_i && pwrite_i &&
                       (paddr_i[3:2] == fpr_pkg::REG_COL_STEP);
  assign stalled     = out_valid_i && !out_ready_i;

  // Input side stalls exactly while a result waits at the output.
  `FPR_ASSERT_IMP(a_ready_follows_out, clk_i, rst_ni, in_valid_i || !in_valid_i, in_ready_i == !stalled)
  // Column step reads back what was written.
  `FPR_ASSERT_NXT(a_step_readback, clk_i, rst_ni, col_step_wr, (paddr_i != $past(paddr_i)) || (prdata_i[fpr_pkg::PHASE_W-1:0] == $past(pwdata_i[fpr_pkg::PHASE_W-1:0])))
  `FPR_ASSERT_NXT(a_out_valid_holds, clk_i, rst_ni, stalled, out_valid_i)
  `FPR_ASSERT_NXT(a_out_payload_holds, clk_i, rst_ni, stalled, $stable(out_real_i) && $stable(out_imag_i) && $stable(out_frame_end_i))

endmodule

bind fourier_phase_ramp_shift fpr_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_fpr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .psel_i          (psel),
  .penable_i       (penable),
  .pwrite_i        (pwrite),
  .paddr_i         (paddr),
  .pwdata_i        (pwdata),
  .prdata_i        (prdata),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_real_i      (out_o.shifted_real),
  .out_imag_i      (out_o.shifted_imag),
  .out_frame_end_i (out_o.frame_end)
);
